// File: hdl/rop_pkg.sv
`default_nettype none

package rop_pkg;

    // Reset value of the overlap threshold, in tenths.
    localparam logic [3:0] TENTHS_RESET = 4'd6;

    // Scale applied to the overlap area before it is compared with the thresholds.
    localparam logic [27:0] OVL_SCALE = 28'd10;

    // One incoming box word.
    typedef struct packed {
        logic [11:0]        box_x;
        logic [11:0]        box_y;
        logic [11:0]        box_w;
        logic [11:0]        box_h;
        logic signed [15:0] box_score;
        logic [15:0]        box_tag;
        logic               batch_end;
    } t_in;

    // One surviving box word.
    typedef struct packed {
        logic [11:0]        kept_x;
        logic [11:0]        kept_y;
        logic [11:0]        kept_w;
        logic [11:0]        kept_h;
        logic signed [15:0] kept_score;
        logic [15:0]        kept_tag;
        logic               kept_last;
    } t_out;

    // Geometry and score that a cell holds and compares.
    typedef struct packed {
        logic [11:0]        x;
        logic [11:0]        y;
        logic [11:0]        w;
        logic [11:0]        h;
        logic signed [15:0] score;
        logic [23:0]        area;
    } t_box;

    // The box under test, travelling down the chain one cell per cycle.
    typedef struct packed {
        logic valid;
        t_box box;
    } t_token;

    // Per-cell control from the sequencer.
    typedef struct packed {
        logic load;
        logic live;
        logic start;
        logic set_mark;
        logic clear;
    } t_cell_ctl;

endpackage

`default_nettype wire

// File: hdl/rect_overlap_suppression.sv
// Loading: one box word per cycle, the batch-ending word included.
// Suppression: in the round for an unsuppressed box i, the box travels down the cell chain
// to the last loaded box; a suppressed box is skipped. Emission: each survivor is picked,
// read from the store and loaded into the output register, skipping suppressed tail entries.
// Reset is synchronous: counters, marks and handshakes clear and the threshold returns to six;
// the box stores hold no defined value until written.
`default_nettype none

module rect_overlap_suppression #(
    parameter int MAX_BOXES = 64
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_in_valid,
    output logic              o_in_stall,
    input  wire rop_pkg::t_in i_in_word,
    output logic              o_out_valid,
    input  wire logic         i_out_stall,
    output rop_pkg::t_out     o_out_word,
    input  wire logic         i_cfg_valid,
    output logic              o_cfg_ready,
    input  wire logic [3:0]   i_cfg_data
);
    import rop_pkg::*;

    localparam int IW = $clog2(MAX_BOXES);
    localparam int CW = $clog2(MAX_BOXES + 1);
    localparam logic [CW-1:0] MAXC = CW'(MAX_BOXES);

    localparam logic [2:0] S_LOAD  = 3'd0;
    localparam logic [2:0] S_START = 3'd1;
    localparam logic [2:0] S_RUN   = 3'd2;
    localparam logic [2:0] S_END   = 3'd3;
    localparam logic [2:0] S_PICK  = 3'd4;
    localparam logic [2:0] S_READ  = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    logic [2:0]    r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [IW-1:0] r_i, n_i;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_lose, n_lose;
    logic [CW-1:0] r_kept, n_kept;
    logic [CW-1:0] r_fi, n_fi;
    logic [CW-1:0] r_tl, n_tl;
    logic [IW-1:0] r_src, n_src;
    logic          r_out_vld;
    logic [3:0]    r_tenths;
    t_out          r_out;
    t_in           r_rd;
    t_in           r_mem [MAX_BOXES];

    logic          w_in_acc;
    logic          w_start, w_set, w_clear, w_load_out;
    logic [CW-1:0] w_n_next, w_tl_m1, w_i_p2;
    logic          w_room, w_any_lose, w_any_sup;
    t_box          w_load_box;
    t_token        w_tok_in  [MAX_BOXES];
    t_token        w_tok_out [MAX_BOXES];
    logic [MAX_BOXES-1:0] w_mark, w_lose, w_sup;

    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_state != S_LOAD);
    assign o_cfg_ready = 1'b1;
    assign w_room      = (r_count < MAXC);
    assign w_n_next    = w_room ? r_count + CW'(1) : r_count;
    assign w_tl_m1     = r_tl - CW'(1);
    assign w_i_p2      = CW'(r_i) + CW'(2);
    assign w_any_lose  = |w_lose;
    assign w_any_sup   = |w_sup;

    // Geometry of the arriving box, with its area worked out once here.
    assign w_load_box = '{x: i_in_word.box_x, y: i_in_word.box_y, w: i_in_word.box_w,
                          h: i_in_word.box_h, score: i_in_word.box_score,
                          area: 24'(i_in_word.box_w) * 24'(i_in_word.box_h)};

    // Row of cells, one per stored box; the token moves one cell to the right each cycle.
    for (genvar k = 0; k < MAX_BOXES; k++) begin : g_cell
        t_cell_ctl w_ctl;

        assign w_ctl.load     = w_in_acc && w_room && (r_count == CW'(k));
        assign w_ctl.live     = (CW'(k) < r_count);
        assign w_ctl.start    = w_start && (r_i == IW'(k));
        assign w_ctl.set_mark = w_set && (r_i == IW'(k));
        assign w_ctl.clear    = w_clear;

        if (k == 0) begin : g_head
            assign w_tok_in[k] = '0;
        end else begin : g_link
            assign w_tok_in[k] = w_tok_out[k-1];
        end

        rop_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (w_ctl),
            .i_load_box (w_load_box),
            .i_tenths   (r_tenths),
            .i_tok      (w_tok_in[k]),
            .o_tok      (w_tok_out[k]),
            .o_mark     (w_mark[k]),
            .o_lose     (w_lose[k]),
            .o_sup      (w_sup[k])
        );
    end

    // Box store for the output path, with a registered read.
    always_ff @(posedge i_clk) begin
        if (w_in_acc && w_room) begin
            r_mem[r_count[IW-1:0]] <= i_in_word;
        end
        r_rd <= r_mem[r_src];
    end

    // Sequencer: load, a suppression round for each unsuppressed box before the last, then compaction and emission.
    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_i        = r_i;
        n_cnt      = r_cnt;
        n_lose     = r_lose | w_any_lose;
        n_kept     = w_any_sup ? r_kept - CW'(1) : r_kept;
        n_fi       = r_fi;
        n_tl       = r_tl;
        n_src      = r_src;
        w_start    = 1'b0;
        w_set      = 1'b0;
        w_clear    = 1'b0;
        w_load_out = 1'b0;
        unique case (r_state)
            S_LOAD: begin
                if (w_in_acc) begin
                    n_count = w_n_next;
                    n_kept  = w_n_next;
                    if (i_in_word.batch_end) begin
                        n_fi = '0;
                        n_tl = w_n_next;
                        n_i  = '0;
                        if (w_n_next < CW'(2)) begin
                            n_state = S_PICK;
                        end else begin
                            n_state = S_START;
                        end
                    end
                end
            end
            S_START: begin
                if (w_mark[r_i]) begin
                    if (w_i_p2 >= r_count) begin
                        n_state = S_PICK;
                    end else begin
                        n_i = r_i + IW'(1);
                    end
                end else begin
                    w_start = 1'b1;
                    n_cnt   = r_count - CW'(1) - CW'(r_i);
                    n_lose  = 1'b0;
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                if (r_cnt == '0) begin
                    n_state = S_END;
                end else begin
                    n_cnt = r_cnt - CW'(1);
                end
            end
            S_END: begin
                n_lose = 1'b0;
                if (r_lose) begin
                    w_set  = 1'b1;
                    n_kept = r_kept - CW'(1);
                end
                if (w_i_p2 >= r_count) begin
                    n_state = S_PICK;
                end else begin
                    n_i     = r_i + IW'(1);
                    n_state = S_START;
                end
            end
            S_PICK: begin
                if (r_kept == '0) begin
                    w_clear = 1'b1;
                    n_count = '0;
                    n_state = S_LOAD;
                end else if (!w_mark[r_fi[IW-1:0]]) begin
                    n_src   = r_fi[IW-1:0];
                    n_fi    = r_fi + CW'(1);
                    n_state = S_READ;
                end else if (w_mark[w_tl_m1[IW-1:0]]) begin
                    // A suppressed tail entry fills the hole and is dropped with it.
                    n_tl = w_tl_m1;
                end else begin
                    n_src   = w_tl_m1[IW-1:0];
                    n_fi    = r_fi + CW'(1);
                    n_tl    = w_tl_m1;
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_out_vld || !i_out_stall) begin
                    w_load_out = 1'b1;
                    n_kept     = r_kept - CW'(1);
                    n_state    = S_PICK;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_count <= '0;
            r_i     <= '0;
            r_cnt   <= '0;
            r_lose  <= 1'b0;
            r_kept  <= '0;
            r_fi    <= '0;
            r_tl    <= '0;
            r_src   <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_i     <= n_i;
            r_cnt   <= n_cnt;
            r_lose  <= n_lose;
            r_kept  <= n_kept;
            r_fi    <= n_fi;
            r_tl    <= n_tl;
            r_src   <= n_src;
        end
    end

    // Threshold register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tenths <= TENTHS_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_tenths <= i_cfg_data;
        end
    end

    // Output register; the sequencer waits only while it holds a word and the consumer stalls.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_load_out) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out <= '{kept_x: r_rd.box_x, kept_y: r_rd.box_y, kept_w: r_rd.box_w,
                       kept_h: r_rd.box_h, kept_score: r_rd.box_score,
                       kept_tag: r_rd.box_tag, kept_last: (r_kept == CW'(1))};
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_word  = r_out;

endmodule

`default_nettype wire

// File: hdl/rop_cell.sv
`default_nettype none

module rop_cell (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire rop_pkg::t_cell_ctl i_ctl,
    input  wire rop_pkg::t_box     i_load_box,
    input  wire logic [3:0]        i_tenths,
    input  wire rop_pkg::t_token   i_tok,
    output rop_pkg::t_token        o_tok,
    output logic                   o_mark,
    output logic                   o_lose,
    output logic                   o_sup
);
    import rop_pkg::*;

    t_box   r_own;
    t_token r_tok;
    logic   r_mark;
    logic   r_hit;
    logic [11:0] r_ww;
    logic [11:0] r_hh;

    logic [12:0] w_cx_t, w_cx_o, w_cy_t, w_cy_o;
    logic [12:0] w_dx, w_dy, w_sx, w_sy;
    logic [11:0] w_x0, w_y0;
    logic signed [13:0] w_x1_t, w_x1_o, w_y1_t, w_y1_o, w_x1, w_y1;
    logic signed [13:0] w_ww_s, w_hh_s;
    logic        w_near;
    logic        w_hit;
    logic [27:0] w_ov10, w_thr_o, w_thr_t;
    logic        w_big, w_eval, w_wins;

    // Keep the own box; written at most once per batch while loading.
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_own <= i_load_box;
        end
    end

    // Centre distance test on integer-halved centres.
    assign w_cx_t = 13'(i_tok.box.x) + 13'(i_tok.box.w[11:1]);
    assign w_cx_o = 13'(r_own.x) + 13'(r_own.w[11:1]);
    assign w_cy_t = 13'(i_tok.box.y) + 13'(i_tok.box.h[11:1]);
    assign w_cy_o = 13'(r_own.y) + 13'(r_own.h[11:1]);
    assign w_dx   = (w_cx_t >= w_cx_o) ? w_cx_t - w_cx_o : w_cx_o - w_cx_t;
    assign w_dy   = (w_cy_t >= w_cy_o) ? w_cy_t - w_cy_o : w_cy_o - w_cy_t;
    assign w_sx   = 13'(i_tok.box.w[11:1]) + 13'(r_own.w[11:1]);
    assign w_sy   = 13'(i_tok.box.h[11:1]) + 13'(r_own.h[11:1]);
    assign w_near = (w_dx < w_sx) && (w_dy < w_sy);

    // Inclusive pixel intersection extents.
    assign w_x0   = (i_tok.box.x > r_own.x) ? i_tok.box.x : r_own.x;
    assign w_y0   = (i_tok.box.y > r_own.y) ? i_tok.box.y : r_own.y;
    assign w_x1_t = $signed({2'b00, i_tok.box.x}) + $signed({2'b00, i_tok.box.w}) - 14'sd1;
    assign w_x1_o = $signed({2'b00, r_own.x}) + $signed({2'b00, r_own.w}) - 14'sd1;
    assign w_y1_t = $signed({2'b00, i_tok.box.y}) + $signed({2'b00, i_tok.box.h}) - 14'sd1;
    assign w_y1_o = $signed({2'b00, r_own.y}) + $signed({2'b00, r_own.h}) - 14'sd1;
    assign w_x1   = (w_x1_t < w_x1_o) ? w_x1_t : w_x1_o;
    assign w_y1   = (w_y1_t < w_y1_o) ? w_y1_t : w_y1_o;
    assign w_ww_s = w_x1 - $signed({2'b00, w_x0}) + 14'sd1;
    assign w_hh_s = w_y1 - $signed({2'b00, w_y0}) + 14'sd1;
    assign w_hit  = i_tok.valid && w_near && (w_ww_s > 14'sd0) && (w_hh_s > 14'sd0);

    // First stage: take the token from the left neighbour, or start one from the own box.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= '0;
            r_hit <= 1'b0;
        end else if (i_ctl.start) begin
            r_tok <= '{valid: !r_mark, box: r_own};
            r_hit <= 1'b0;
        end else begin
            r_tok <= i_tok;
            r_hit <= w_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ww <= w_ww_s[11:0];
        r_hh <= w_hh_s[11:0];
    end

    // Second stage: area ratio test against both boxes and the score decision.
    assign w_ov10  = 28'(r_ww) * 28'(r_hh) * OVL_SCALE;
    assign w_thr_o = 28'(i_tenths) * 28'(r_own.area);
    assign w_thr_t = 28'(i_tenths) * 28'(r_tok.box.area);
    assign w_big   = (w_ov10 > w_thr_o) || (w_ov10 > w_thr_t);
    assign w_eval  = r_tok.valid && r_hit && i_ctl.live && !r_mark;
    assign w_wins  = r_tok.box.score > r_own.score;

    assign o_sup  = w_eval && w_big && w_wins;
    assign o_lose = w_eval && w_big && !w_wins;

    // Suppression mark of the own box.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            r_mark <= 1'b0;
        end else if (i_ctl.set_mark || o_sup) begin
            r_mark <= 1'b1;
        end
    end

    assign o_tok  = r_tok;
    assign o_mark = r_mark;

endmodule

`default_nettype wire

// File: hdl/rop_check.sv
`default_nettype none

module rop_check (
    input wire logic          i_clk,
    input wire logic          i_rst_n,
    input wire logic          i_in_valid,
    input wire logic          o_in_stall,
    input wire rop_pkg::t_in  i_in_word,
    input wire logic          o_out_valid,
    input wire logic          i_out_stall,
    input wire rop_pkg::t_out o_out_word
);
    import rop_pkg::*;

    // Reset leaves no result word pending.
    a_reset_idle: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("result word pending after reset");

    // A stalled result word stays put.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_word))
        else $error("stalled result word changed");

    // The word that ends a batch closes the input until the batch has been processed.
    a_end_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_in_word.batch_end |=> o_in_stall)
        else $error("input open after the batch-ending word");

    // While a batch is still being emitted no new box is taken.
    a_emit_closed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_word.kept_last |-> o_in_stall)
        else $error("input open in the middle of a batch's results");

endmodule

bind rect_overlap_suppression rop_check u_rop_check (.*);

`default_nettype wire

// File: tb/rect_overlap_suppression_tb.sv
`timescale 1ns / 100ps

module rect_overlap_suppression_tb;

    import rop_pkg::*;

    localparam int NBOX        = 64;
    localparam int CYCLE_LIMIT = 2000000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    t_in         i_in_word = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    t_out        o_out_word;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [3:0]  i_cfg_data = 4'd0;

    rect_overlap_suppression #(.MAX_BOXES(NBOX)) DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_word(i_in_word),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_word(o_out_word),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // Words waiting to be sent, and survivors still expected.
    t_in  pending_words[$];
    t_out kept_expected[$];

    // Shadow of the block's batch store and threshold.
    t_in        batch_boxes[NBOX];
    int         batch_len = 0;
    logic [3:0] thr_tenths = TENTHS_RESET;

    int   mismatches = 0;
    int   cycles = 0;
    int   hold_cycles = 0;
    bit   driver_busy = 1'b0;

    function automatic longint box_area(t_in b);
        return longint'(b.box_w) * longint'(b.box_h);
    endfunction

    function automatic longint intersect_area(t_in a, t_in b);
        longint ax, ay, aw, ah, bx, by, bw, bh, dx, dy, x0, x1, y0, y1;
        ax = longint'(a.box_x); ay = longint'(a.box_y);
        aw = longint'(a.box_w); ah = longint'(a.box_h);
        bx = longint'(b.box_x); by = longint'(b.box_y);
        bw = longint'(b.box_w); bh = longint'(b.box_h);
        dx = (ax + aw / 2) - (bx + bw / 2);
        dy = (ay + ah / 2) - (by + bh / 2);
        if (dx < 0) dx = -dx;
        if (dy < 0) dy = -dy;
        if (!(dx < aw / 2 + bw / 2 && dy < ah / 2 + bh / 2)) return 0;
        x0 = (ax > bx) ? ax : bx;
        x1 = (ax + aw - 1 < bx + bw - 1) ? ax + aw - 1 : bx + bw - 1;
        y0 = (ay > by) ? ay : by;
        y1 = (ay + ah - 1 < by + bh - 1) ? ay + ah - 1 : by + bh - 1;
        if (x1 < x0 || y1 < y0) return 0;
        return (x1 - x0 + 1) * (y1 - y0 + 1);
    endfunction

    // Store an accepted word; on the end of a batch run greedy suppression,
    // compact from the tail and queue the survivors.
    task automatic predict_survivors(t_in w);
        bit     dead[NBOX];
        int     n, i, j;
        longint ov, t;
        t_out   o;
        if (batch_len < NBOX) begin
            batch_boxes[batch_len] = w;
            batch_len++;
        end
        if (!w.batch_end) return;
        n = batch_len;
        t = longint'(thr_tenths);
        foreach (dead[k]) dead[k] = 1'b0;
        if (n >= 2) begin
            for (i = 0; i < n; i++) begin
                if (dead[i]) continue;
                for (j = i + 1; j < n; j++) begin
                    if (dead[j]) continue;
                    ov = intersect_area(batch_boxes[i], batch_boxes[j]) * 10;
                    if (ov > t * box_area(batch_boxes[j]) || ov > t * box_area(batch_boxes[i])) begin
                        if (batch_boxes[i].box_score > batch_boxes[j].box_score) dead[j] = 1'b1;
                        else dead[i] = 1'b1;
                    end
                end
            end
            i = 0;
            while (i < n) begin
                if (!dead[i]) begin
                    i++;
                end else begin
                    dead[i] = dead[n - 1];
                    batch_boxes[i] = batch_boxes[n - 1];
                    n--;
                end
            end
        end
        for (i = 0; i < n; i++) begin
            o.kept_x = batch_boxes[i].box_x;
            o.kept_y = batch_boxes[i].box_y;
            o.kept_w = batch_boxes[i].box_w;
            o.kept_h = batch_boxes[i].box_h;
            o.kept_score = batch_boxes[i].box_score;
            o.kept_tag = batch_boxes[i].box_tag;
            o.kept_last = (i == n - 1);
            kept_expected.push_back(o);
        end
        batch_len = 0;
    endtask

    // Driver: one word at a time from the pending queue, with a random gap before each.
    int in_gap = 0;
    always @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            predict_survivors(i_in_word);
            in_gap = $urandom_range(0, 19);
            if ($urandom_range(0, 3) == 0) in_gap = 0;
            if (in_gap == 0 && pending_words.size() > 0 && i_rst_n) begin
                i_in_word <= pending_words.pop_front();
            end else begin
                i_in_valid <= 1'b0;
            end
        end else if (!i_in_valid && i_rst_n && pending_words.size() > 0) begin
            if (in_gap > 0) begin
                in_gap--;
            end else begin
                i_in_word <= pending_words.pop_front();
                i_in_valid <= 1'b1;
            end
        end
        driver_busy <= (pending_words.size() > 0) || i_in_valid;
    end

    // Long receiver hold-off, counted down here.
    always @(posedge i_clk) begin
        if (hold_cycles > 0) hold_cycles <= hold_cycles - 1;
    end

    // Monitor: check each survivor against the oldest expectation, stall at random.
    int out_gap = 0;
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (o_out_valid && !i_out_stall) begin
            if (kept_expected.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("Unexpected survivor word %h", o_out_word);
            end else begin
                if (o_out_word !== kept_expected[0]) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Survivor mismatch: expected %h, got %h",
                                 kept_expected[0], o_out_word);
                end
                void'(kept_expected.pop_front());
            end
            out_gap = $urandom_range(0, 19);
            if ($urandom_range(0, 3) == 0) out_gap = 0;
        end
        if (hold_cycles > 0) begin
            i_out_stall <= 1'b1;
        end else if (out_gap > 0) begin
            out_gap--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // Hard limit on the run.
    always @(posedge i_clk) begin
        if (cycles > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic t_in make_box(bit fin);
        t_in b;
        b.box_x = 12'($urandom_range(0, 4095));
        b.box_y = 12'($urandom_range(0, 4095));
        b.box_w = 12'($urandom_range(1, 4095));
        b.box_h = 12'($urandom_range(1, 4095));
        b.box_score = 16'($urandom);
        b.box_tag = 16'($urandom);
        b.batch_end = fin;
        return b;
    endfunction

    // A cluster of boxes near one spot, so that many pairs overlap.
    function automatic t_in near_box(int cx, int cy, bit fin);
        t_in b;
        b = make_box(fin);
        b.box_w = 12'($urandom_range(20, 120));
        b.box_h = 12'($urandom_range(20, 120));
        b.box_x = 12'(cx + $urandom_range(0, 30));
        b.box_y = 12'(cy + $urandom_range(0, 30));
        if ($urandom_range(0, 3) == 0) b.box_score = 16'sh0100;
        return b;
    endfunction

    task automatic queue_batch(int len, bit clustered);
        int cx, cy;
        cx = $urandom_range(0, 3800);
        cy = $urandom_range(0, 3800);
        for (int k = 0; k < len; k++)
            pending_words.push_back(clustered ? near_box(cx, cy, k == len - 1)
                                              : make_box(k == len - 1));
    endtask

    task automatic wait_drained();
        while (pending_words.size() > 0 || driver_busy || kept_expected.size() > 0)
            @(posedge i_clk);
        repeat (NBOX * (NBOX + 4)) @(posedge i_clk);
    endtask

    task automatic write_threshold(logic [3:0] v);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        thr_tenths = v;
    endtask

    int   sent;
    t_in  b;

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: single box, extremes, equal scores, identical boxes.
        b = '0; b.box_w = 12'd1; b.box_h = 12'd1; b.batch_end = 1'b1;
        pending_words.push_back(b);
        b = '1; b.box_score = 16'sh7FFF;
        b.batch_end = 1'b0; pending_words.push_back(b);
        b.box_score = -16'sh8000; b.box_tag = 16'h0000; b.box_x = 12'd0; b.box_y = 12'd0;
        b.batch_end = 1'b1; pending_words.push_back(b);
        b = '0; b.box_x = 12'd100; b.box_y = 12'd100; b.box_w = 12'd50; b.box_h = 12'd50;
        b.box_score = 16'sh0200; b.box_tag = 16'hAAAA;
        pending_words.push_back(b);
        b.box_tag = 16'h5555; pending_words.push_back(b);
        b.box_x = 12'd110; b.box_score = 16'sh0300; pending_words.push_back(b);
        b.box_x = 12'd2000; b.box_tag = 16'h1234; b.batch_end = 1'b1; pending_words.push_back(b);
        b = '0; b.box_w = 12'd4095; b.box_h = 12'd4095; b.box_score = -16'sd1;
        pending_words.push_back(b);
        b.box_x = 12'd4094; b.box_y = 12'd4094; b.box_w = 12'd1; b.box_h = 12'd1;
        b.box_score = -16'sd1; b.batch_end = 1'b1; pending_words.push_back(b);
        wait_drained();

        // Threshold extremes, with an overflowing batch under threshold 0.
        write_threshold(4'd0);
        queue_batch(NBOX + 3, 1'b1);
        wait_drained();
        write_threshold(4'd15);
        queue_batch(4, 1'b1);
        wait_drained();
        write_threshold(4'd10);
        queue_batch(4, 1'b1);
        wait_drained();
        write_threshold(4'd6);

        // Long hold-off on the output while a second batch keeps being offered.
        hold_cycles = 3000;
        queue_batch(8, 1'b1);
        queue_batch(4, 1'b1);
        while (hold_cycles > 0) @(posedge i_clk);
        wait_drained();

        // Random batches, mostly small and clustered.
        sent = 0;
        while (sent < 15) begin
            int len;
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 6);
            queue_batch(len, $urandom_range(0, 4) != 0);
            sent += len;
            if ($urandom_range(0, 5) == 0) begin
                wait_drained();
                write_threshold(4'($urandom_range(0, 15)));
            end
        end
        wait_drained();

        if (mismatches == 0 && kept_expected.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// File: files.f
hdl/rop_pkg.sv
hdl/rop_cell.sv
hdl/rect_overlap_suppression.sv
hdl/rop_check.sv
tb/rect_overlap_suppression_tb.sv
